// File: design/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character constants and the hex digit helper for the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Escape parser phase. Code 3 is unused and behaves as plain.
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIG   = 2'd2
  } upd_phase_t;

  // Group of up to three result bytes produced by one input character.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } upd_grp_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: design/upd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_decode
// Escape state registers and the per-character decode into a result group.
// ----------------------------------------------------------------------------
module upd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        char_in,
  input  logic              last_in,
  output upd_pkg::upd_grp_t grp
);
  import upd_pkg::*;

  upd_phase_t phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [4:0] hx_c, hx_h;

  always_comb begin
    logic [2:0][7:0] b;
    logic [1:0]      n;
    logic            do_plain;
    b         = '0;
    n         = 2'd0;
    do_plain  = 1'b0;
    phase_nxt = PH_PLAIN;
    held_nxt  = held_r;
    hx_c      = hex_val(char_in);
    hx_h      = hex_val(held_r);
    case (phase_r)
      PH_PCT: begin
        if (hx_c[4] && !last_in) begin
          held_nxt  = char_in;
          phase_nxt = PH_DIG;
        end else begin
          b[0]     = CH_PERCENT;
          n        = 2'd1;
          do_plain = 1'b1;
        end
      end
      PH_DIG: begin
        if (hx_h[4] && hx_c[4]) begin
          b[0] = {hx_h[3:0], hx_c[3:0]};
          n    = 2'd1;
        end else begin
          b[0]     = CH_PERCENT;
          b[1]     = held_r;
          n        = 2'd2;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase
    if (do_plain) begin
      if (char_in == CH_PLUS) begin
        b[n] = CH_SPACE;
        n    = n + 2'd1;
      end else if (char_in == CH_PERCENT && !last_in) begin
        phase_nxt = PH_PCT;
      end else begin
        b[n] = char_in;
        n    = n + 2'd1;
      end
    end
    // The end of a string always leaves the parser in the plain phase.
    if (last_in) begin
      phase_nxt = PH_PLAIN;
    end
    grp.bytes = b;
    grp.cnt   = n;
    grp.last  = last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      held_r  <= 8'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// File: design/upd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_out_buf
// Result register holding one group and handing its bytes out one at a time.
// ----------------------------------------------------------------------------
module upd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  upd_pkg::upd_grp_t grp,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import upd_pkg::*;

  logic [2:0][7:0] bytes_r;
  logic            last_r;
  logic [1:0]      rem_r, rem_nxt;
  logic [1:0]      pos_r, pos_nxt;
  logic            pop;

  assign out_valid = (rem_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_byte  = bytes_r[pos_r];
  assign out_last  = last_r && (rem_r == 2'd1);
  // Free now, or its final byte leaves in this cycle.
  assign can_load  = (rem_r == 2'd0) || ((rem_r == 2'd1) && pop);

  always_comb begin
    rem_nxt = rem_r;
    pos_nxt = pos_r;
    if (load) begin
      rem_nxt = grp.cnt;
      pos_nxt = 2'd0;
    end else if (pop) begin
      rem_nxt = rem_r - 2'd1;
      pos_nxt = pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      pos_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= grp.bytes;
      last_r  <= grp.last;
    end
  end

endmodule

// File: design/url_percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming decoder for form-encoded text: plus to space, %XX to one byte.
// ----------------------------------------------------------------------------
//   Channel  Handshake          Payload
//   in       in_valid/in_stall  in_byte[7:0], in_last
//   out      out_valid/out_stall out_byte[7:0], out_last
//
// A character is captured in the input register, decoded in the next cycle by
// short logic into a group of zero to three bytes, and that group is loaded
// into the result register, which hands its bytes out one per cycle while
// out_stall is low. Sustained rate is one character per cycle while each
// character yields at most one byte and out_stall is low; a group of two or
// three bytes holds the input while the result register drains.
// Reset (rst_n low, synchronous) empties both registers and returns the
// escape parser to the plain phase.
// in_stall rises only when a captured transaction cannot yet hand its group
// to the result register; out_stall holds the current byte in place.
// ----------------------------------------------------------------------------
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import upd_pkg::*;

  // Input register.
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  upd_grp_t grp;
  logic     can_load;
  logic     s1_go;
  logic     in_acc;

  // A captured character moves on when its group fits; a group with no bytes
  // (an escape merely advancing) always moves on.
  assign s1_go    = s1_vld_r && ((grp.cnt == 2'd0) || can_load);
  assign in_stall = s1_vld_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  upd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_go),
    .char_in (s1_byte_r),
    .last_in (s1_last_r),
    .grp     (grp)
  );

  upd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_go && (grp.cnt != 2'd0)),
    .grp       (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
